[hdl/tdfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdfp_pkg
// Shared constants and types for the tagged decimal field parser.
// ----------------------------------------------------------------------------
package tdfp_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TAG_W   = 7;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;

  // text message capacity and its counter width
  localparam int unsigned TEXT_CAP = 50;
  localparam int unsigned CNT_W    = $clog2(TEXT_CAP + 1);

  // per-tag table
  localparam int unsigned TABLE_DEPTH = 1 << TAG_W;

  // character codes
  localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
  localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_TEXT      = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_FIRST_TAG = 8'h21;
  localparam logic [BYTE_W-1:0] CH_LAST_TAG  = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_DIGIT_0   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_DIGIT_9   = 8'h39;

  // decoded word waiting for its table lookup
  typedef struct packed {
    logic               point_valid;
    logic [TAG_W-1:0]   point_tag;
    logic [VALUE_W-1:0] point_value;
    logic               line_end;
    logic               text_start;
    logic               text_char_valid;
    logic [BYTE_W-1:0]  text_char;
    logic [POS_W-1:0]   text_pos;
    logic               text_done;
  } tdfp_item_t;

  // finished result word
  typedef struct packed {
    logic               point_valid;
    logic [TAG_W-1:0]   point_tag;
    logic [VALUE_W-1:0] point_value;
    logic               point_changed;
    logic               line_end;
    logic               text_start;
    logic               text_char_valid;
    logic [BYTE_W-1:0]  text_char;
    logic [POS_W-1:0]   text_pos;
    logic               text_done;
  } tdfp_result_t;

endpackage
`default_nettype wire

[hdl/tdfp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdfp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hdl/tdfp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdfp_front
// Byte decoder: tag, accumulator and text state, plus the lookup stage
// register that holds one decoded word.
// ----------------------------------------------------------------------------
module tdfp_front
  import tdfp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              adv_i,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  output logic      [TAG_W-1:0]  rd_addr_o,
  output logic                   s1_vld_o,
  output tdfp_item_t             s1_item_o
);

  logic [BYTE_W-1:0]  tag_q, tag_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               in_text_q, in_text_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               s1_vld_q, s1_vld_d;
  tdfp_item_t         item_q, item_d;

  logic               is_digit;
  logic               tag_printable;
  logic [VALUE_W-1:0] acc_times_ten;

  assign is_digit      = (rx_byte_i >= CH_DIGIT_0) && (rx_byte_i <= CH_DIGIT_9);
  assign tag_printable = (tag_q >= CH_FIRST_TAG) && (tag_q <= CH_LAST_TAG);
  assign acc_times_ten = (acc_q << 3) + (acc_q << 1);

  // table is read at the pending tag for every accepted byte
  assign rd_addr_o = tag_q[TAG_W-1:0];

  // decode of one byte
  always_comb begin
    tag_d     = tag_q;
    acc_d     = acc_q;
    in_text_d = in_text_q;
    count_d   = count_q;
    item_d    = '0;

    // store text character while there is room
    if (in_text_q && (count_q < CNT_W'(TEXT_CAP))) begin
      item_d.text_char_valid = 1'b1;
      item_d.text_char       = rx_byte_i;
      item_d.text_pos        = POS_W'(count_q);
      count_d                = count_q + 1'b1;
    end

    // start of a new message
    if (rx_byte_i == CH_TEXT) begin
      in_text_d         = 1'b1;
      count_d           = '0;
      item_d.text_start = 1'b1;
    end

    // cr or lf ends the message
    if (((rx_byte_i == CH_CR) || (rx_byte_i == CH_LF)) && in_text_d) begin
      in_text_d        = 1'b0;
      item_d.text_done = 1'b1;
    end

    // tag and value parsing
    if (!in_text_d) begin
      priority if (rx_byte_i == CH_NUL) begin
        tag_d = '0;
      end else if ((tag_q != '0) && is_digit) begin
        acc_d = acc_times_ten + VALUE_W'(rx_byte_i - CH_DIGIT_0);
      end else begin
        tag_d = rx_byte_i;
        if (tag_printable) begin
          item_d.point_valid = 1'b1;
          item_d.point_tag   = tag_q[TAG_W-1:0];
          item_d.point_value = acc_q;
          acc_d              = '0;
        end
      end
      if (rx_byte_i == CH_LF) begin
        tag_d           = '0;
        acc_d           = '0;
        item_d.line_end = 1'b1;
      end
    end
  end

  // lookup stage occupancy
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept_i) begin
      s1_vld_d = 1'b1;
    end else if (adv_i) begin
      s1_vld_d = 1'b0;
    end
  end

  // parser state and stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q     <= '0;
      acc_q     <= '0;
      in_text_q <= 1'b0;
      count_q   <= '0;
      s1_vld_q  <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      if (accept_i) begin
        tag_q     <= tag_d;
        acc_q     <= acc_d;
        in_text_q <= in_text_d;
        count_q   <= count_d;
      end
    end
  end

  // decoded word payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_d;
    end
  end

  assign s1_vld_o  = s1_vld_q;
  assign s1_item_o = item_q;

endmodule
`default_nettype wire

[hdl/tdfp_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tdfp_table
// Last-value table: read data compare, write-back with forwarding of the
// most recent write, per-entry valid bits, and the output register.
// ----------------------------------------------------------------------------
module tdfp_table
  import tdfp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [TAG_W-1:0] rd_addr_i,
  input  wire logic             s1_vld_i,
  input  wire tdfp_item_t       s1_item_i,
  input  wire logic             out_stall_i,
  output logic                  adv_o,
  output logic                  out_vld_o,
  output tdfp_result_t          out_o
);

  logic [VALUE_W-1:0]     rd_data;
  logic [TABLE_DEPTH-1:0] vbit_q;
  logic                   wr_vld_q;
  logic [TAG_W-1:0]       wr_idx_q;
  logic [VALUE_W-1:0]     wr_val_q;
  logic                   out_vld_q;
  tdfp_result_t           out_q;

  logic                   out_take;
  logic                   wr_en;
  logic [VALUE_W-1:0]     old_val;

  // output register frees when empty or when its word is taken
  assign out_take = !out_vld_q || !out_stall_i;
  assign adv_o    = s1_vld_i && out_take;
  assign wr_en    = adv_o && s1_item_i.point_valid;

  tdfp_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_item_i.point_tag),
    .wdata_i (s1_item_i.point_value),
    .re_i    (accept_i),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  // stored value: last write forwarded, unwritten entries read as zero
  always_comb begin
    priority if (wr_vld_q && (wr_idx_q == s1_item_i.point_tag)) begin
      old_val = wr_val_q;
    end else if (vbit_q[s1_item_i.point_tag]) begin
      old_val = rd_data;
    end else begin
      old_val = '0;
    end
  end

  // valid bits and forwarding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbit_q   <= '0;
      wr_vld_q <= 1'b0;
    end else if (wr_en) begin
      vbit_q[s1_item_i.point_tag] <= 1'b1;
      wr_vld_q                    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wr_idx_q <= s1_item_i.point_tag;
      wr_val_q <= s1_item_i.point_value;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_take) begin
      out_vld_q <= s1_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      out_q.point_valid     <= s1_item_i.point_valid;
      out_q.point_tag       <= s1_item_i.point_tag;
      out_q.point_value     <= s1_item_i.point_value;
      out_q.point_changed   <= s1_item_i.point_valid && (old_val != s1_item_i.point_value);
      out_q.line_end        <= s1_item_i.line_end;
      out_q.text_start      <= s1_item_i.text_start;
      out_q.text_char_valid <= s1_item_i.text_char_valid;
      out_q.text_char       <= s1_item_i.text_char;
      out_q.text_pos        <= s1_item_i.text_pos;
      out_q.text_done       <= s1_item_i.text_done;
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;

endmodule
`default_nettype wire

[hdl/tagged_decimal_field_parser.sv]
// A result word is registered first in the lookup stage and then in the output
// register. Throughput: one byte per cycle while the output is not stalled; the
// last-value table is read when the byte is accepted, and is compared and
// written back when the word advances out of the lookup stage.
// Reset clears the pending tag, accumulator and text state, and marks every
// table entry as zero through per-entry valid bits, so bytes are taken
// straight after reset.
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_decimal_field_parser
// Parses serial lines of one-character tags followed by decimal values,
// reports each closed tag with a changed flag, and passes text messages
// through character by character.
// ----------------------------------------------------------------------------
module tagged_decimal_field_parser
  import tdfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [BYTE_W-1:0]  rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    point_valid_o,
  output logic      [TAG_W-1:0]   point_tag_o,
  output logic      [VALUE_W-1:0] point_value_o,
  output logic                    point_changed_o,
  output logic                    line_end_o,
  output logic                    text_start_o,
  output logic                    text_char_valid_o,
  output logic      [BYTE_W-1:0]  text_char_o,
  output logic      [POS_W-1:0]   text_pos_o,
  output logic                    text_done_o
);

  logic             accept;
  logic             adv;
  logic             s1_vld;
  logic [TAG_W-1:0] rd_addr;
  tdfp_item_t       s1_item;
  tdfp_result_t     res;

  // input handshake: stall only while the lookup stage is blocked
  assign in_stall_o = s1_vld && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  tdfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .adv_i     (adv),
    .rx_byte_i (rx_byte_i),
    .rd_addr_o (rd_addr),
    .s1_vld_o  (s1_vld),
    .s1_item_o (s1_item)
  );

  tdfp_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rd_addr_i   (rd_addr),
    .s1_vld_i    (s1_vld),
    .s1_item_i   (s1_item),
    .out_stall_i (out_stall_i),
    .adv_o       (adv),
    .out_vld_o   (out_valid_o),
    .out_o       (res)
  );

  // result word fields
  assign point_valid_o     = res.point_valid;
  assign point_tag_o       = res.point_tag;
  assign point_value_o     = res.point_value;
  assign point_changed_o   = res.point_changed;
  assign line_end_o        = res.line_end;
  assign text_start_o      = res.text_start;
  assign text_char_valid_o = res.text_char_valid;
  assign text_char_o       = res.text_char;
  assign text_pos_o        = res.text_pos;
  assign text_done_o       = res.text_done;

endmodule
`default_nettype wire
